/* hw/rtl/vertex_triple_dedup_assert.svh */
// Assertion macros used by the checker of the vertex de-duplication block.
// Each macro expects signals named i_clk and i_rst_n in the using module.
`ifndef VERTEX_TRIPLE_DEDUP_ASSERT_SVH
`define VERTEX_TRIPLE_DEDUP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define VTD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define VTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/vtd_pkg.sv */
// Package for the vertex de-duplication block: sizes, table entry type and
// the request structs between the controller and the triple table.
package vtd_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 1024;
    localparam int INDEX_W     = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = ADDR_W + 1;
    localparam int ENTRY_W     = 3 * INDEX_W;

    // Width of the vertex index on the result port.
    localparam int VIDX_W      = 10;

    typedef logic [ENTRY_W-1:0] t_entry;
    typedef logic [ADDR_W-1:0]  t_addr;

    // Write request into the triple table.
    typedef struct packed {
        logic   en;
        t_addr  addr;
        t_entry data;
    } t_tbl_wr;

    // Read request into the triple table.
    typedef struct packed {
        logic  en;
        t_addr addr;
    } t_tbl_rd;

endpackage

/* hw/rtl/vtd_table.sv */
// Table of unique vertex triples: one write port and one registered read port.
// Depends on vtd_pkg for the depth, the entry type and the request structs.
module vtd_table
    import vtd_pkg::*;
(
    input  logic    i_clk,
    input  t_tbl_wr i_wr,
    input  t_tbl_rd i_rd,
    output t_entry  o_rd_data
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/vertex_triple_dedup.sv */
// Vertex de-duplication: a corner that hits table entry j shows its result once entries 0 to j
// are read and compared; a miss shows it once all N entries are read, N being the table fill.
// The table scan reads one entry per cycle through the single read port of the
// table; busy is high until the result.
// Results are shown for one cycle with o_strobe and cannot be held off by the receiver.
// Synchronous reset empties the table.
module vertex_triple_dedup
    import vtd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_start_mesh,
    input  logic [INDEX_W-1:0] i_position_index,
    input  logic [INDEX_W-1:0] i_texture_index,
    input  logic [INDEX_W-1:0] i_normal_index,
    output logic               o_strobe,
    output logic [VIDX_W-1:0]  o_vertex_index,
    output logic               o_is_new,
    output logic               o_overflow,
    output logic [INDEX_W-1:0] o_new_position,
    output logic [INDEX_W-1:0] o_new_texture,
    output logic [INDEX_W-1:0] o_new_normal
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state               r_state, n_state;
    logic [COUNT_W-1:0]   r_count, n_count;
    t_entry               r_key, n_key;
    logic [COUNT_W-1:0]   r_rd_addr, n_rd_addr;
    logic                 r_cmp_vld, n_cmp_vld;
    t_addr                r_cmp_addr, n_cmp_addr;
    logic                 r_strobe, n_strobe;
    logic [VIDX_W-1:0]    r_vidx, n_vidx;
    logic                 r_is_new, n_is_new;
    logic                 r_ovf, n_ovf;
    logic [INDEX_W-1:0]   r_new_pos, n_new_pos;
    logic [INDEX_W-1:0]   r_new_tex, n_new_tex;
    logic [INDEX_W-1:0]   r_new_nrm, n_new_nrm;

    t_tbl_wr tbl_wr;
    t_tbl_rd tbl_rd;
    t_entry  tbl_rd_data;
    logic    scan_left;
    logic    hit;

    vtd_table u_table (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd      (tbl_rd),
        .o_rd_data (tbl_rd_data)
    );

    // Entries still to be read, and a match on the entry read last cycle.
    assign scan_left = (r_rd_addr < r_count);
    assign hit       = r_cmp_vld && (tbl_rd_data == r_key);

    // Scan controller: read entries in order, stop at the first match,
    // append on a miss when there is room, else flag an overflow.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_key      = r_key;
        n_rd_addr  = r_rd_addr;
        n_cmp_vld  = 1'b0;
        n_cmp_addr = r_cmp_addr;
        n_strobe   = 1'b0;
        n_vidx     = r_vidx;
        n_is_new   = r_is_new;
        n_ovf      = r_ovf;
        n_new_pos  = r_new_pos;
        n_new_tex  = r_new_tex;
        n_new_nrm  = r_new_nrm;
        tbl_wr     = '0;
        tbl_rd     = '0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    // Zero-based indices; an index of zero wraps to all ones.
                    n_key = {i_position_index - INDEX_W'(1),
                             i_texture_index  - INDEX_W'(1),
                             i_normal_index   - INDEX_W'(1)};
                    n_rd_addr = '0;
                    if (i_start_mesh) begin
                        n_count = '0;
                    end
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    n_vidx    = VIDX_W'(r_cmp_addr);
                    n_is_new  = 1'b0;
                    n_ovf     = 1'b0;
                    n_new_pos = '0;
                    n_new_tex = '0;
                    n_new_nrm = '0;
                    n_strobe  = 1'b1;
                    n_state   = ST_IDLE;
                end else if (!scan_left) begin
                    // Every valid entry was compared without a match.
                    if (r_count == COUNT_W'(TABLE_DEPTH)) begin
                        n_vidx    = '0;
                        n_is_new  = 1'b0;
                        n_ovf     = 1'b1;
                        n_new_pos = '0;
                        n_new_tex = '0;
                        n_new_nrm = '0;
                    end else begin
                        tbl_wr.en   = 1'b1;
                        tbl_wr.addr = r_count[ADDR_W-1:0];
                        tbl_wr.data = r_key;
                        n_count     = r_count + COUNT_W'(1);
                        n_vidx      = VIDX_W'(r_count);
                        n_is_new    = 1'b1;
                        n_ovf       = 1'b0;
                        n_new_pos   = r_key[ENTRY_W-1 -: INDEX_W];
                        n_new_tex   = r_key[2*INDEX_W-1 -: INDEX_W];
                        n_new_nrm   = r_key[INDEX_W-1:0];
                    end
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    // Issue the next read; its data is compared next cycle.
                    tbl_rd.en   = 1'b1;
                    tbl_rd.addr = r_rd_addr[ADDR_W-1:0];
                    n_rd_addr   = r_rd_addr + COUNT_W'(1);
                    n_cmp_vld   = 1'b1;
                    n_cmp_addr  = r_rd_addr[ADDR_W-1:0];
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
            r_strobe  <= n_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_rd_addr  <= n_rd_addr;
        r_cmp_addr <= n_cmp_addr;
        r_vidx     <= n_vidx;
        r_is_new   <= n_is_new;
        r_ovf      <= n_ovf;
        r_new_pos  <= n_new_pos;
        r_new_tex  <= n_new_tex;
        r_new_nrm  <= n_new_nrm;
    end

    assign busy           = (r_state == ST_SCAN);
    assign o_strobe       = r_strobe;
    assign o_vertex_index = r_vidx;
    assign o_is_new       = r_is_new;
    assign o_overflow     = r_ovf;
    assign o_new_position = r_new_pos;
    assign o_new_texture  = r_new_tex;
    assign o_new_normal   = r_new_nrm;

endmodule

/* hw/rtl/vtd_checker.sv */
// Port-level checker for the vertex de-duplication block, bound to the top level.
// Depends on vtd_pkg and on the assertion macros in vertex_triple_dedup_assert.svh.
`include "vertex_triple_dedup_assert.svh"

module vtd_checker
    import vtd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_strobe,
    input logic [VIDX_W-1:0] o_vertex_index,
    input logic              o_is_new,
    input logic              o_overflow
);

    // An accepted item keeps the block busy in the next cycle.
    `VTD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")

    // A result only follows a busy cycle.
    `VTD_ASSERT_NOW(a_strobe_after_busy, o_strobe, $past(busy), "result without a scan")

    // The end of a scan always delivers a result.
    `VTD_ASSERT_NOW(a_end_gives_result, $fell(busy) && $past(i_rst_n), o_strobe, "scan ended without a result")

    // An overflow is never also a new vertex, and returns index zero.
    `VTD_ASSERT_NOW(a_overflow_result, o_strobe && o_overflow, !o_is_new && (o_vertex_index == '0), "bad overflow result")

endmodule

bind vertex_triple_dedup vtd_checker u_vtd_checker (.*);
